/* sv/mrme_pkg.sv */
// Shared constants, codes and the CRC-16/MODBUS byte step for the Modbus RTU master engine.
package mrme_pkg;

  // Store sizes.
  localparam int BUFFER_WORDS = 64;
  localparam int FRAME_BYTES  = 256;
  localparam int BUF_AW       = $clog2(BUFFER_WORDS);
  localparam int FRAME_AW     = $clog2(FRAME_BYTES);

  // Write quantity limits that keep a request inside both stores.
  localparam int FRAME_CAP       = (FRAME_BYTES < 255) ? FRAME_BYTES : 255;
  localparam int REG_FRAME_LIMIT = (FRAME_CAP - 13) / 2;
  localparam int REG_LIMIT_I     = (BUFFER_WORDS < REG_FRAME_LIMIT) ? BUFFER_WORDS
                                                                    : REG_FRAME_LIMIT;
  localparam int COIL_BYTE_I     = ((2 * BUFFER_WORDS) < (FRAME_CAP - 9)) ? (2 * BUFFER_WORDS)
                                                                          : (FRAME_CAP - 9);
  localparam logic [15:0] REG_LIMIT      = 16'(REG_LIMIT_I);
  localparam logic [15:0] COIL_BIT_LIMIT = 16'(8 * COIL_BYTE_I);
  localparam logic [9:0]  FRAME_LIM      = 10'(FRAME_BYTES);
  localparam logic [7:0]  BUF_LIM        = 8'(BUFFER_WORDS);

  // CRC and value constants.
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] COIL_ON_WORD = 16'hFF00;
  localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
  localparam logic [15:0] WORD_ALL_ONE = 16'hFFFF;

  // Actions.
  localparam logic [2:0] ACT_LOAD  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_PULL  = 3'd2;
  localparam logic [2:0] ACT_RX    = 3'd3;
  localparam logic [2:0] ACT_TICK  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_RESP = 2'd2;
  localparam logic [1:0] KIND_LOAD = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SLAVE = 3'd1;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd2;
  localparam logic [2:0] ST_EXCEPTION = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;
  localparam logic [2:0] ST_BAD_CRC   = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX = 3'd6;
  localparam logic [2:0] ST_UNSUPP    = 3'd7;

  // Phases of a transaction.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  // Function codes.
  localparam logic [6:0] FC_RD_COILS   = 7'h01;
  localparam logic [6:0] FC_RD_DISC    = 7'h02;
  localparam logic [6:0] FC_RD_HOLD    = 7'h03;
  localparam logic [6:0] FC_RD_INPUT   = 7'h04;
  localparam logic [6:0] FC_WR_COIL    = 7'h05;
  localparam logic [6:0] FC_WR_REG     = 7'h06;
  localparam logic [6:0] FC_WR_COILS   = 7'h0F;
  localparam logic [6:0] FC_WR_REGS    = 7'h10;
  localparam logic [6:0] FC_MASK_WR    = 7'h16;
  localparam logic [6:0] FC_RW_REGS    = 7'h17;

  // One byte through the reflected CRC-16/MODBUS register.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

/* sv/mrme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mrme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/modbus_rtu_master_engine.sv */
// Modbus RTU master engine: request builder, byte streamer, response checker and unpacker.
//
//   channel    direction  handshake                    payload
//   command    in         start, busy                  action .. rx_byte
//   result     out        result_strobe (one cycle)    result_kind .. response_length
//   config     in         cfg_we                       cfg_wdata (response timeout ticks)
//
// Load, tick and most receive bytes are handled from idle; the result is registered.
// Pull and read word go through S_PULL or S_RESP for the registered frame or response store read.
// Start builds the frame into the frame store one byte at a time (S_BADDR reads the transmit
// word, S_BWR writes the byte), then S_BCRC0 and S_BCRC1 write the CRC. A complete response
// unpacks one word at a time (S_U0, S_U1, S_U2) through the single frame store read port.
// Reset is synchronous; store valid bits clear at once, so no clearing pass is needed.
// Results cannot be stalled; the next command may be taken while a result is shown.
module modbus_rtu_master_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [7:0]  slave_id,
  input  logic [6:0]  function_code,
  input  logic [15:0] read_address,
  input  logic [15:0] read_quantity,
  input  logic [15:0] write_address,
  input  logic [15:0] write_quantity,
  input  logic        coil_on,
  input  logic [7:0]  word_index,
  input  logic [15:0] word_value,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        result_strobe,
  output logic [1:0]  result_kind,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [2:0]  status,
  output logic [7:0]  exception_code,
  output logic [15:0] response_word,
  output logic [6:0]  response_length
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PULL  = 4'd1;
  localparam logic [3:0] S_RESP  = 4'd2;
  localparam logic [3:0] S_BADDR = 4'd3;
  localparam logic [3:0] S_BWR   = 4'd4;
  localparam logic [3:0] S_BCRC0 = 4'd5;
  localparam logic [3:0] S_BCRC1 = 4'd6;
  localparam logic [3:0] S_U0    = 4'd7;
  localparam logic [3:0] S_U1    = 4'd8;
  localparam logic [3:0] S_U2    = 4'd9;

  logic [3:0]  state;
  logic [1:0]  phase;
  logic [8:0]  pos;
  logic [7:0]  bleft;
  logic [15:0] crc;
  logic [15:0] elapsed;
  logic [6:0]  stored_len;
  logic [15:0] timeout;
  logic [mrme_pkg::BUFFER_WORDS-1:0] tx_valid;
  logic [mrme_pkg::BUFFER_WORDS-1:0] resp_valid;

  // Request registers.
  logic [7:0]  req_slave;
  logic [6:0]  req_fc;
  logic [15:0] req_ra;
  logic [15:0] req_rq;
  logic [15:0] req_wa;
  logic [15:0] req_wq;
  logic [7:0]  req_nb;
  logic [7:0]  req_idx;

  // Build, receive and unpack working registers.
  logic [8:0]  bk;
  logic [8:0]  n_len;
  logic        pull_inr;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  ui;
  logic [7:0]  ulimit;
  logic [6:0]  ulen;
  logic [7:0]  ufirst;

  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // RAM ports.
  logic                          fr_we;
  logic [mrme_pkg::FRAME_AW-1:0] fr_waddr;
  logic [7:0]                    fr_wdata;
  logic [mrme_pkg::FRAME_AW-1:0] fr_raddr;
  logic [7:0]                    fr_rdata;
  logic                          tx_we;
  logic [mrme_pkg::BUF_AW-1:0]   tx_raddr;
  logic [15:0]                   tx_rdata;
  logic                          rs_we;
  logic [15:0]                   rs_wdata;
  logic [15:0]                   rs_rdata;

  // Start-time decode of the incoming command.
  logic        fc_ok;
  logic [15:0] wq_sat;
  logic [7:0]  nb_in;
  logic [8:0]  n_in;

  always_comb begin
    fc_ok = (function_code == mrme_pkg::FC_RD_COILS) || (function_code == mrme_pkg::FC_RD_DISC)
         || (function_code == mrme_pkg::FC_RD_HOLD)  || (function_code == mrme_pkg::FC_RD_INPUT)
         || (function_code == mrme_pkg::FC_WR_COIL)  || (function_code == mrme_pkg::FC_WR_REG)
         || (function_code == mrme_pkg::FC_WR_COILS) || (function_code == mrme_pkg::FC_WR_REGS)
         || (function_code == mrme_pkg::FC_MASK_WR)  || (function_code == mrme_pkg::FC_RW_REGS);
    wq_sat = write_quantity;
    if (function_code == mrme_pkg::FC_WR_COIL) begin
      wq_sat = coil_on ? mrme_pkg::COIL_ON_WORD : 16'h0000;
    end else if (function_code == mrme_pkg::FC_WR_COILS) begin
      if (write_quantity > mrme_pkg::COIL_BIT_LIMIT) wq_sat = mrme_pkg::COIL_BIT_LIMIT;
    end else if ((function_code == mrme_pkg::FC_WR_REGS)
              || (function_code == mrme_pkg::FC_RW_REGS)) begin
      if (write_quantity > mrme_pkg::REG_LIMIT) wq_sat = mrme_pkg::REG_LIMIT;
    end
    nb_in = 8'((17'(wq_sat) + 17'd7) >> 3);
    case (function_code)
      mrme_pkg::FC_WR_COILS: n_in = 9'd7 + 9'(nb_in);
      mrme_pkg::FC_WR_REGS:  n_in = 9'd7 + (9'(wq_sat) << 1);
      mrme_pkg::FC_RW_REGS:  n_in = 9'd11 + (9'(wq_sat) << 1);
      mrme_pkg::FC_MASK_WR:  n_in = 9'd8;
      default:               n_in = 9'd6;
    endcase
  end

  // Request byte generator for the build sequence.
  logic        hdr;
  logic [8:0]  off;
  logic [8:0]  off2;
  logic [8:0]  dstart;
  logic [8:0]  rel;
  logic [15:0] txw;
  logic        wq_fc;
  logic [7:0]  bbyte;

  always_comb begin
    hdr    = (req_fc <= mrme_pkg::FC_RD_INPUT) || (req_fc == mrme_pkg::FC_RW_REGS);
    off    = hdr ? 9'd6 : 9'd2;
    off2   = (req_fc >= mrme_pkg::FC_WR_COIL) ? off + 9'd2 : off;
    dstart = ((req_fc == mrme_pkg::FC_WR_REG) || (req_fc == mrme_pkg::FC_MASK_WR))
           ? off2 : off2 + 9'd3;
    rel      = bk - dstart;
    tx_raddr = mrme_pkg::BUF_AW'(rel >> 1);
    txw      = tx_valid[tx_raddr] ? tx_rdata : 16'h0000;
    wq_fc    = (req_fc == mrme_pkg::FC_WR_COIL) || (req_fc == mrme_pkg::FC_WR_COILS)
            || (req_fc == mrme_pkg::FC_WR_REGS) || (req_fc == mrme_pkg::FC_RW_REGS);
    if (bk == 9'd0) begin
      bbyte = req_slave;
    end else if (bk == 9'd1) begin
      bbyte = {1'b0, req_fc};
    end else if (hdr && (bk < 9'd6)) begin
      case (bk[2:0])
        3'd2:    bbyte = req_ra[15:8];
        3'd3:    bbyte = req_ra[7:0];
        3'd4:    bbyte = req_rq[15:8];
        default: bbyte = req_rq[7:0];
      endcase
    end else if (bk < off2) begin
      bbyte = (bk == off) ? req_wa[15:8] : req_wa[7:0];
    end else if (wq_fc && (bk < off2 + 9'd2)) begin
      bbyte = (bk == off2) ? req_wq[15:8] : req_wq[7:0];
    end else if ((req_fc == mrme_pkg::FC_WR_COILS) && (bk == off2 + 9'd2)) begin
      bbyte = req_nb;
    end else if (wq_fc && (bk == off2 + 9'd2)) begin
      bbyte = {req_wq[6:0], 1'b0};
    end else if (req_fc == mrme_pkg::FC_WR_COILS) begin
      bbyte = rel[0] ? txw[15:8] : txw[7:0];
    end else begin
      bbyte = rel[0] ? txw[7:0] : txw[15:8];
    end
  end

  // Receive byte evaluation.
  logic [15:0] rx_crc;
  logic [8:0]  rx_pos;
  logic [7:0]  rx_bl;
  logic        rx_check;
  logic        rx_done;
  logic        is_coil;
  logic        is_regs;
  logic [7:0]  uw;
  logic [7:0]  ulim_in;
  logic [6:0]  ulen_in;

  always_comb begin
    rx_crc   = mrme_pkg::crc_step(crc, rx_byte);
    rx_pos   = pos + 9'd1;
    rx_check = (rx_pos == 9'd5);
    rx_bl    = (bleft != 8'd0) ? bleft - 8'd1 : 8'd0;
    if (rx_check) begin
      if ((req_fc <= mrme_pkg::FC_RD_INPUT) || (req_fc == mrme_pkg::FC_RW_REGS)) begin
        rx_bl = b2;
      end else if (req_fc == mrme_pkg::FC_MASK_WR) begin
        rx_bl = 8'd5;
      end else begin
        rx_bl = 8'd3;
      end
    end
    rx_done = (rx_pos >= 9'd5) && (rx_bl == 8'd0);
    is_coil = (req_fc == mrme_pkg::FC_RD_COILS) || (req_fc == mrme_pkg::FC_RD_DISC);
    is_regs = (req_fc == mrme_pkg::FC_RD_HOLD) || (req_fc == mrme_pkg::FC_RD_INPUT)
           || (req_fc == mrme_pkg::FC_RW_REGS);
    uw      = is_coil ? 8'((9'(b2) + 9'd1) >> 1) : (b2 >> 1);
    ulim_in = (uw > mrme_pkg::BUF_LIM) ? mrme_pkg::BUF_LIM : uw;
    ulen_in = (ulim_in > 8'd127) ? 7'd127 : ulim_in[6:0];
  end

  // Unpack addresses and data.
  logic [9:0] ua3;
  logic [9:0] ua4;
  logic [7:0] usec;

  always_comb begin
    ua3  = 10'({ui, 1'b0}) + 10'd3;
    ua4  = 10'({ui, 1'b0}) + 10'd4;
    usec = ((ua4 < mrme_pkg::FRAME_LIM) && (!is_coil || (ua4 < 10'(b2) + 10'd3)))
         ? fr_rdata : 8'h00;
    rs_we    = (state == S_U2);
    rs_wdata = is_coil ? {usec, ufirst} : {ufirst, usec};
    tx_we    = accept && (action == mrme_pkg::ACT_LOAD) && (word_index < mrme_pkg::BUF_LIM);
  end

  // Frame store port selection.
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = mrme_pkg::FRAME_AW'(bk);
    fr_wdata = bbyte;
    case (state)
      S_BWR: begin
        fr_we = ({1'b0, bk} < mrme_pkg::FRAME_LIM);
      end
      S_BCRC0: begin
        fr_we    = ({1'b0, bk} < mrme_pkg::FRAME_LIM);
        fr_wdata = crc[7:0];
      end
      S_BCRC1: begin
        fr_we    = ({1'b0, bk} < mrme_pkg::FRAME_LIM);
        fr_wdata = crc[15:8];
      end
      S_IDLE: begin
        fr_we    = accept && (action == mrme_pkg::ACT_RX) && (phase == mrme_pkg::PH_RECV)
                && ({1'b0, pos} < mrme_pkg::FRAME_LIM);
        fr_waddr = mrme_pkg::FRAME_AW'(pos);
        fr_wdata = rx_byte;
      end
      default: ;
    endcase
    case (state)
      S_U0:    fr_raddr = mrme_pkg::FRAME_AW'(ua3);
      S_U1:    fr_raddr = mrme_pkg::FRAME_AW'(ua4);
      default: fr_raddr = mrme_pkg::FRAME_AW'(pos);
    endcase
  end

  mrme_ram #(.WIDTH(8), .DEPTH(mrme_pkg::FRAME_BYTES)) u_frame (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  mrme_ram #(.WIDTH(16), .DEPTH(mrme_pkg::BUFFER_WORDS)) u_tx (
    .clk(clk), .we(tx_we), .waddr(word_index[mrme_pkg::BUF_AW-1:0]), .wdata(word_value),
    .raddr(tx_raddr), .rdata(tx_rdata)
  );

  mrme_ram #(.WIDTH(16), .DEPTH(mrme_pkg::BUFFER_WORDS)) u_resp (
    .clk(clk), .we(rs_we), .waddr(ui[mrme_pkg::BUF_AW-1:0]), .wdata(rs_wdata),
    .raddr(word_index[mrme_pkg::BUF_AW-1:0]), .rdata(rs_rdata)
  );

  logic [15:0] el_inc;
  assign el_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= mrme_pkg::PH_IDLE;
      pos             <= 9'd0;
      bleft           <= 8'd8;
      crc             <= mrme_pkg::CRC_INIT;
      elapsed         <= 16'd0;
      stored_len      <= 7'd0;
      timeout         <= mrme_pkg::TIMEOUT_RST;
      tx_valid        <= '0;
      resp_valid      <= '0;
      req_slave       <= 8'd0;
      req_fc          <= 7'd0;
      req_ra          <= 16'd0;
      req_rq          <= 16'd0;
      req_wa          <= 16'd0;
      req_wq          <= 16'd0;
      result_strobe   <= 1'b0;
      result_kind     <= 2'd0;
      tx_byte         <= 8'd0;
      tx_last         <= 1'b0;
      status          <= 3'd0;
      exception_code  <= 8'd0;
      response_word   <= 16'd0;
      response_length <= 7'd0;
    end else begin
      result_strobe   <= 1'b0;
      result_kind     <= mrme_pkg::KIND_TX;
      tx_byte         <= 8'd0;
      tx_last         <= 1'b0;
      status          <= mrme_pkg::ST_OK;
      exception_code  <= 8'd0;
      response_word   <= 16'd0;
      response_length <= 7'd0;
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              mrme_pkg::ACT_LOAD: begin
                result_strobe <= 1'b1;
                result_kind   <= mrme_pkg::KIND_LOAD;
                if (tx_we) begin
                  tx_valid[word_index[mrme_pkg::BUF_AW-1:0]] <= 1'b1;
                end else begin
                  status <= mrme_pkg::ST_BAD_INDEX;
                end
              end
              mrme_pkg::ACT_START: begin
                if (!fc_ok) begin
                  phase           <= mrme_pkg::PH_IDLE;
                  result_strobe   <= 1'b1;
                  result_kind     <= mrme_pkg::KIND_DONE;
                  status          <= mrme_pkg::ST_UNSUPP;
                  response_length <= stored_len;
                end else begin
                  req_slave <= slave_id;
                  req_fc    <= function_code;
                  req_ra    <= read_address;
                  req_rq    <= read_quantity;
                  req_wa    <= write_address;
                  req_wq    <= wq_sat;
                  req_nb    <= nb_in;
                  n_len     <= n_in;
                  bk        <= 9'd0;
                  crc       <= mrme_pkg::CRC_INIT;
                  state     <= S_BADDR;
                end
              end
              mrme_pkg::ACT_PULL: begin
                if ((phase == mrme_pkg::PH_SEND) && (bleft != 8'd0)) begin
                  pull_inr <= ({1'b0, pos} < mrme_pkg::FRAME_LIM);
                  state    <= S_PULL;
                end
              end
              mrme_pkg::ACT_RX: begin
                if (phase == mrme_pkg::PH_RECV) begin
                  crc   <= rx_crc;
                  pos   <= rx_pos;
                  bleft <= rx_bl;
                  if (pos == 9'd0) b0 <= rx_byte;
                  if (pos == 9'd1) b1 <= rx_byte;
                  if (pos == 9'd2) b2 <= rx_byte;
                  if (rx_check && (b0 != req_slave)) begin
                    phase           <= mrme_pkg::PH_IDLE;
                    result_strobe   <= 1'b1;
                    result_kind     <= mrme_pkg::KIND_DONE;
                    status          <= mrme_pkg::ST_BAD_SLAVE;
                    response_length <= stored_len;
                  end else if (rx_check && (b1[6:0] != req_fc)) begin
                    phase           <= mrme_pkg::PH_IDLE;
                    result_strobe   <= 1'b1;
                    result_kind     <= mrme_pkg::KIND_DONE;
                    status          <= mrme_pkg::ST_BAD_FUNC;
                    response_length <= stored_len;
                  end else if (rx_check && b1[7]) begin
                    phase           <= mrme_pkg::PH_IDLE;
                    result_strobe   <= 1'b1;
                    result_kind     <= mrme_pkg::KIND_DONE;
                    status          <= mrme_pkg::ST_EXCEPTION;
                    exception_code  <= b2;
                    response_length <= stored_len;
                  end else if (rx_done) begin
                    if (rx_crc != 16'h0000) begin
                      phase           <= mrme_pkg::PH_IDLE;
                      result_strobe   <= 1'b1;
                      result_kind     <= mrme_pkg::KIND_DONE;
                      status          <= mrme_pkg::ST_BAD_CRC;
                      response_length <= stored_len;
                    end else if ((is_coil || is_regs) && (ulim_in != 8'd0)) begin
                      ui     <= 8'd0;
                      ulimit <= ulim_in;
                      ulen   <= ulen_in;
                      state  <= S_U0;
                    end else begin
                      phase           <= mrme_pkg::PH_IDLE;
                      result_strobe   <= 1'b1;
                      result_kind     <= mrme_pkg::KIND_DONE;
                      if (is_coil || is_regs) begin
                        stored_len      <= ulen_in;
                        response_length <= ulen_in;
                      end else begin
                        response_length <= stored_len;
                      end
                    end
                  end
                end
              end
              mrme_pkg::ACT_TICK: begin
                if (phase == mrme_pkg::PH_RECV) begin
                  elapsed <= el_inc;
                  if (el_inc > timeout) begin
                    phase           <= mrme_pkg::PH_IDLE;
                    result_strobe   <= 1'b1;
                    result_kind     <= mrme_pkg::KIND_DONE;
                    status          <= mrme_pkg::ST_TIMEOUT;
                    response_length <= stored_len;
                  end
                end
              end
              mrme_pkg::ACT_READ: begin
                req_idx <= word_index;
                state   <= S_RESP;
              end
              default: ;
            endcase
          end
        end
        // Hand out one request byte from the frame store.
        S_PULL: begin
          result_strobe <= 1'b1;
          result_kind   <= mrme_pkg::KIND_TX;
          tx_byte       <= pull_inr ? fr_rdata : 8'h00;
          pos           <= pos + 9'd1;
          bleft         <= bleft - 8'd1;
          if (bleft == 8'd1) begin
            tx_last <= 1'b1;
            phase   <= mrme_pkg::PH_RECV;
            pos     <= 9'd0;
            bleft   <= 8'd8;
            crc     <= mrme_pkg::CRC_INIT;
            elapsed <= 16'd0;
          end
          state <= S_IDLE;
        end
        // Answer a response store read.
        S_RESP: begin
          result_strobe   <= 1'b1;
          result_kind     <= mrme_pkg::KIND_RESP;
          response_length <= stored_len;
          if (req_idx < mrme_pkg::BUF_LIM) begin
            response_word <= resp_valid[req_idx[mrme_pkg::BUF_AW-1:0]] ? rs_rdata : 16'h0000;
          end else begin
            response_word <= mrme_pkg::WORD_ALL_ONE;
            status        <= mrme_pkg::ST_BAD_INDEX;
          end
          state <= S_IDLE;
        end
        // Build the request: read the transmit word, then write one byte.
        S_BADDR: begin
          state <= S_BWR;
        end
        S_BWR: begin
          crc   <= mrme_pkg::crc_step(crc, bbyte);
          bk    <= bk + 9'd1;
          state <= (bk + 9'd1 == n_len) ? S_BCRC0 : S_BADDR;
        end
        S_BCRC0: begin
          bk    <= bk + 9'd1;
          state <= S_BCRC1;
        end
        S_BCRC1: begin
          phase <= mrme_pkg::PH_SEND;
          pos   <= 9'd0;
          bleft <= 8'(n_len + 9'd2);
          state <= S_IDLE;
        end
        // Unpack one response word from two frame bytes.
        S_U0: begin
          state <= S_U1;
        end
        S_U1: begin
          ufirst <= (ua3 < mrme_pkg::FRAME_LIM) ? fr_rdata : 8'h00;
          state  <= S_U2;
        end
        S_U2: begin
          resp_valid[ui[mrme_pkg::BUF_AW-1:0]] <= 1'b1;
          if (ui + 8'd1 == ulimit) begin
            stored_len      <= ulen;
            phase           <= mrme_pkg::PH_IDLE;
            result_strobe   <= 1'b1;
            result_kind     <= mrme_pkg::KIND_DONE;
            response_length <= ulen;
            state           <= S_IDLE;
          end else begin
            ui    <= ui + 8'd1;
            state <= S_U0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A pull always answers in the following cycle.
  a_pull_answers: assert property (@(posedge clk) disable iff (rst)
    (state == S_PULL) |=> (result_strobe && (result_kind == mrme_pkg::KIND_TX)))
    else $error("pull did not produce a tx byte");

  // The last CRC byte moves the engine to receiving.
  a_last_recv: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result_kind == mrme_pkg::KIND_TX) && tx_last)
      |-> (phase == mrme_pkg::PH_RECV))
    else $error("last tx byte without receive phase");

  // A finished build leaves the engine ready to send.
  a_build_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCRC1) |=> ((phase == mrme_pkg::PH_SEND) && !busy))
    else $error("build did not end in send phase");

  // The stored length never exceeds the response store.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result_kind == mrme_pkg::KIND_DONE))
      |-> (8'(response_length) <= mrme_pkg::BUF_LIM))
    else $error("response length beyond store size");

endmodule
